@@ rtl/fdb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_pkg: shared definitions for the decimating FIR filter
// Holds the field widths, the low-pass design table, the coefficient ROM
// builder and the control word that travels with each tap through the MAC.
// ----------------------------------------------------------------------------
package fdb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 17;
  localparam int ROM_DEPTH = 64;
  localparam int ROM_AW    = 6;
  localparam int ROM_W     = 32;
  localparam int OUT_MAX   = 65535;
  localparam int OUT_MIN   = -65536;

  // First half of the symmetric low-pass design, in units of 1e-6.
  localparam int DesignMicro [ROM_DEPTH/2] = '{
    632, -432, -893, 261, 1339, 93, -1955, -834,
    2608, 2142, -3035, -4119, 2866, 6725, -1658, -9740,
    -1047, 12738, 5683, -15076, -12640, 15876, 22328, -13922,
    -35455, 7242, 53958, 8633, -85114, -51212, 178146, 415860
  };

  typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] rom_t;

  // Control word that accompanies one tap through the multiply-accumulate.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Builds the full symmetric table scaled to Q1.(coef_bits-1), rounded to
  // nearest with ties away from zero.
  function automatic rom_t build_rom(int coef_bits);
    rom_t   rom;
    int     k;
    longint micro;
    longint mag;
    longint q;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      k     = (i < ROM_DEPTH/2) ? i : (ROM_DEPTH - 1 - i);
      micro = longint'(DesignMicro[k]);
      mag   = (micro < 0) ? -micro : micro;
      q     = ((mag << (coef_bits - 1)) + 64'd500000) / 64'd1000000;
      if (micro < 0) begin
        q = -q;
      end
      rom[i] = q[ROM_W-1:0];
    end
    return rom;
  endfunction

endpackage

@@ rtl/fdb_history.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_history: circular sample history
// One write port and one registered read port. A fill count stands in for
// the reset clear: entries not yet written read back as zero.
// ----------------------------------------------------------------------------
module fdb_history import fdb_pkg::*; #(
  parameter int TAPS = 64,
  parameter int AW   = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic signed [SAMPLE_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic signed [SAMPLE_W-1:0] rd_data_o
);

  localparam int FW = $clog2(TAPS + 1);

  logic signed [SAMPLE_W-1:0] mem [TAPS];
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic                       rd_ok_q;
  logic [FW-1:0]              fill_q;
  logic [FW-1:0]              fill_d;

  // Writes go in pointer order from zero, so an entry holds data once its
  // index is below the fill count.
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (fill_q != FW'(TAPS))) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      rd_ok_q <= (FW'(rd_addr_i) < fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : '0;

endmodule

@@ rtl/fdb_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_mac: shared multiply-accumulate unit
// Looks up the tap coefficient, multiplies it by the history sample and
// accumulates over one pass of taps. Three register stages.
// ----------------------------------------------------------------------------
module fdb_mac import fdb_pkg::*; #(
  parameter int COEF_BITS = 16,
  parameter int AW        = 6,
  parameter int ACC_W     = 38
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctl_t                   ctl_i,
  input  logic [AW-1:0]              tap_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [ACC_W-1:0]    acc_o,
  output logic                       done_o
);

  localparam rom_t CoefRom = build_rom(COEF_BITS);
  localparam int   TW      = ((AW > ROM_AW) ? AW : ROM_AW) + 1;
  localparam int   PW      = SAMPLE_W + COEF_BITS;

  logic [TW-1:0]               tap_ext;
  logic signed [COEF_BITS-1:0] coef_d;
  logic signed [COEF_BITS-1:0] coef_q;
  logic signed [PW-1:0]        prod_q;
  logic signed [ACC_W-1:0]     acc_q;
  mac_ctl_t                    ctl1_q;
  mac_ctl_t                    ctl2_q;
  logic                        done_q;

  // Taps beyond the table use a zero coefficient.
  always_comb begin
    tap_ext = TW'(tap_i);
    coef_d  = '0;
    if (tap_ext < TW'(ROM_DEPTH)) begin
      coef_d = CoefRom[tap_ext[ROM_AW-1:0]][COEF_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid && ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
    prod_q <= sample_i * coef_q;
    if (ctl2_q.valid) begin
      if (ctl2_q.first) begin
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

@@ rtl/fir_decimate_by_two_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_decimate_by_two_core: 64-tap low-pass FIR with decimation by two
// Circular history, one shared multiply-accumulate unit and a sequencer.
// ----------------------------------------------------------------------------
// Each accepted request carries one signed 16-bit sample. The sample is
// written into a circular history of TAPS entries (cleared at reset), and the
// sequencer then walks the taps from the newest sample back, feeding one tap
// per cycle into a single multiply-accumulate unit whose coefficients are
// fixed Q1.(COEF_BITS-1) low-pass values. A request keeps the input stalled
// until its pass is through, so no new request is taken before the last one
// is done, whether its result is kept or discarded; the length of the pass
// is set by the one multiplier, which handles one tap per cycle, plus the
// history read, product and accumulate registers that the last tap has to
// pass before the sum is final. The input stalls for the whole pass. Only
// the first, third, fifth request and so on produce a result: the sum is
// rounded to nearest (ties upward) into sample units and saturated to
// -65536..65535. Results sit in an output register, so a new request is
// accepted while an earlier result still waits downstream; if the next
// result is ready before that one is taken, the block holds it and stalls
// the input until the output register frees up.
// ----------------------------------------------------------------------------
module fir_decimate_by_two_core import fdb_pkg::*; #(
  parameter int TAPS      = 64,
  parameter int COEF_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_W-1:0]    filtered_o
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = SAMPLE_W + COEF_BITS + $clog2(TAPS);
  localparam int SH    = COEF_BITS - 1;
  localparam int RW    = ACC_W + 1 - SH;

  localparam logic signed [RW-1:0] OutMax = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] OutMin = RW'(OUT_MIN);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e   state_q, state_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          phase_q, phase_d;
  logic          out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_q, out_d;

  logic                       accept;
  logic                       out_free;
  logic                       load_out;
  logic                       last_tap;
  mac_ctl_t                   ctl;
  logic signed [SAMPLE_W-1:0] hist_data;
  logic signed [ACC_W-1:0]    acc;
  logic                       mac_done;
  logic signed [ACC_W:0]      acc_bias;
  logic signed [RW-1:0]       rounded;
  logic signed [OUT_W-1:0]    saturated;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_tap = (cnt_q == AW'(TAPS - 1));

  assign ctl.valid = (state_q == S_RUN);
  assign ctl.first = (cnt_q == '0);
  assign ctl.last  = last_tap;

  fdb_history #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_addr_i (wp_q),
    .wr_data_i (sample_i),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (hist_data)
  );

  fdb_mac #(
    .COEF_BITS (COEF_BITS),
    .AW        (AW),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .tap_i    (cnt_q),
    .sample_i (hist_data),
    .acc_o    (acc),
    .done_o   (mac_done)
  );

  // Round half up: add half a unit, then an arithmetic shift floors.
  always_comb begin
    acc_bias  = (ACC_W + 1)'(acc) + ((ACC_W + 1)'(1) <<< (SH - 1));
    rounded   = RW'(acc_bias >>> SH);
    saturated = rounded[OUT_W-1:0];
    if (rounded > OutMax) begin
      saturated = OutMax[OUT_W-1:0];
    end else if (rounded < OutMin) begin
      saturated = OutMin[OUT_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rd_addr_d = rd_addr_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_addr_d = wp_q;
          wp_d      = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
          cnt_d     = '0;
          phase_d   = !phase_q;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        rd_addr_d = (rd_addr_q == '0) ? AW'(TAPS - 1) : rd_addr_q - 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (last_tap) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          if (!phase_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = saturated;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rd_addr_q   <= '0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rd_addr_q   <= rd_addr_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_q;

endmodule

@@ rtl/fdb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_checker: port-level checks for the decimating FIR
// Watches the top-level ports only and is bound to the core.
// ----------------------------------------------------------------------------
module fdb_checker import fdb_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [OUT_W-1:0]    filtered_o
);

  // A stalled request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i))
    else $error("stalled request changed or vanished");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_o))
    else $error("stalled result changed or vanished");

  // An accepted request keeps the block busy right after acceptance, so the input is not taken again too soon.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon after a request");

  // A new result only appears at the end of a pass, while the input was stalled.
  a_result_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a filter pass");

  // The block never stalls its input while idle, so a stall must begin right
  // after a request was offered.
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stalled without a request");

endmodule

bind fir_decimate_by_two_core fdb_checker u_fdb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .sample_i    (sample_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .filtered_o  (filtered_o)
);
